### rtl/deadline_sorted_timer_queue_macros.svh
// assertion macros for the sorted timer queue
// no dependencies; included by modules that check their own logic
`ifndef DEADLINE_SORTED_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tsq assertion failed");
`define TSQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tsq assertion failed");
`else
`define TSQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/tsq_pkg.sv
// shared types and constants for the sorted timer queue
// no dependencies
package tsq_pkg;
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 48;
    localparam int MAX_RESULTS    = 16;
    localparam int STEP_W         = 20;
    localparam int TIMEOUT_W      = 31;
    localparam int ID_W           = 4;
    localparam int TAG_W          = 32;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_RM   = 2'd1,
        REQ_TICK = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_RM  = 2'd1,
        KIND_EXP = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_DL,
        S_ADD_CMP,
        S_ADD_FIN,
        S_RM_RD,
        S_RM_CHK,
        S_TK_RD,
        S_TK_DL,
        S_TK_CMP,
        S_TK_END,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic set;
        logic clr;
    } t_act_cmd;
endpackage

### rtl/tsq_ifs.sv
// request, response and configuration channels of the sorted timer queue
// no dependencies
interface tsq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [30:0] timeout_value;
    logic [3:0]  slot_id;
    logic [31:0] user_tag;
    modport source(output valid, req_type, timeout_value, slot_id, user_tag, input ready);
    modport sink(input valid, req_type, timeout_value, slot_id, user_tag, output ready);
endinterface

interface tsq_resp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  resp_kind;
    logic        ok;
    logic [3:0]  slot_out;
    logic [31:0] tag_out;
    logic        last;
    modport source(output valid, resp_kind, ok, slot_out, tag_out, last, input ready);
    modport sink(input valid, resp_kind, ok, slot_out, tag_out, last, output ready);
endinterface

interface tsq_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] us_per_tick;
    modport source(output valid, us_per_tick, input ready);
    modport sink(input valid, us_per_tick, output ready);
endinterface

### rtl/deadline_sorted_timer_queue.sv
// Sorted timer queue. Pending timers sit in a deadline-sorted order memory
// (slot numbers, head first) beside an entry memory of deadline and tag per slot;
// both are single-port-per-access memories with a registered read, and every accepted
// add, remove and tick walks the order memory one position at a time. An add inserts
// behind every queued timer with an earlier or equal deadline; a remove walks the
// whole queue; a rejected add or remove goes straight to its response. A tick takes
// expired timers from the head until it finds the first timer not yet due, the queue
// runs out or sixteen have expired, and when any expired it closes up the order memory
// before the next request is taken; expiries wait while the consumer stalls. Reset
// needs no clearing pass. Deadlines saturate at the top of the time range.
`include "deadline_sorted_timer_queue_macros.svh"
module deadline_sorted_timer_queue #(
    parameter int NUM_TIMERS = tsq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = tsq_pkg::TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsq_cfg_if.sink    i_cfg,
    tsq_req_if.sink    i_req,
    tsq_resp_if.source o_resp
);
    import tsq_pkg::*;
    localparam int SW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TW = TIME_WIDTH;
    localparam int EW = TW + TAG_W;

    logic [SW-1:0] ord_mem [NUM_TIMERS];
    logic [EW-1:0] ent_mem [NUM_TIMERS];

    t_state          r_state, n_state;
    logic [TW-1:0]   r_now, n_now;
    logic [STEP_W-1:0] r_step;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_k, n_k;
    logic [TW-1:0]   r_dl, n_dl;
    logic [SW-1:0]   r_slot, n_slot;
    logic [ID_W-1:0] r_rid, n_rid;
    logic [TAG_W-1:0] r_tag, n_tag;
    t_kind           r_kind, n_kind;
    logic            r_ok, n_ok;
    logic            r_found, n_found;
    logic            r_pend, n_pend;
    logic [SW-1:0]   r_pslot, n_pslot;
    logic [TAG_W-1:0] r_ptag, n_ptag;

    logic            r_out_valid;
    t_kind           r_out_kind;
    logic            r_out_ok;
    logic [ID_W-1:0] r_out_slot;
    logic [TAG_W-1:0] r_out_tag;
    logic            r_out_last;

    logic            ld_out;
    t_kind           ld_kind;
    logic            ld_ok;
    logic [ID_W-1:0] ld_slot;
    logic [TAG_W-1:0] ld_tag;
    logic            ld_last;

    logic [SW-1:0] r_ord_q;
    logic [EW-1:0] r_ent_q;
    logic          ord_re, ord_we, ent_re, ent_we;
    logic [SW-1:0] ord_ra, ord_wa, ord_wd, ent_ra;

    t_act_cmd      act_cmd;
    logic [SW-1:0] act_idx;
    logic          act_hit, any_free;
    logic [SW-1:0] free_idx;

    logic          req_acc, out_free, id_ok, due;
    logic [TW:0]   add_sum, tick_sum;
    logic [TW-1:0] ent_dl;
    logic [CW:0]   sh_src, rm_next;

    tsq_active_set #(.NUM_TIMERS(NUM_TIMERS)) u_act (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (act_cmd),
        .i_idx      (act_idx),
        .o_hit      (act_hit),
        .o_any_free (any_free),
        .o_free_idx (free_idx)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_resp.ready;

    assign add_sum  = {1'b0, r_now} + (TW + 1)'(i_req.timeout_value);
    assign tick_sum = {1'b0, r_now} + (TW + 1)'(r_step);
    assign ent_dl   = r_ent_q[EW-1:TAG_W];
    assign due      = (ent_dl <= r_now);
    assign sh_src   = {1'b0, r_idx} + {1'b0, r_k};
    assign rm_next  = {1'b0, r_idx} + (CW + 1)'(1);
    assign id_ok    = ({{(32 - ID_W){1'b0}}, i_req.slot_id} < 32'(NUM_TIMERS));

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        if (ord_re) begin
            r_ord_q <= ord_mem[ord_ra];
        end
        if (ent_we) begin
            ent_mem[r_slot] <= {r_dl, r_tag};
        end
        if (ent_re) begin
            r_ent_q <= ent_mem[ent_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_step      <= STEP_W'(1);
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            if (i_cfg.valid && i_cfg.ready) begin
                r_step <= i_cfg.us_per_tick;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_dl    <= n_dl;
        r_slot  <= n_slot;
        r_rid   <= n_rid;
        r_tag   <= n_tag;
        r_kind  <= n_kind;
        r_ok    <= n_ok;
        r_found <= n_found;
        r_pslot <= n_pslot;
        r_ptag  <= n_ptag;
        if (ld_out) begin
            r_out_kind <= ld_kind;
            r_out_ok   <= ld_ok;
            r_out_slot <= ld_slot;
            r_out_tag  <= ld_tag;
            r_out_last <= ld_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_now   = r_now;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_k     = r_k;
        n_dl    = r_dl;
        n_slot  = r_slot;
        n_rid   = r_rid;
        n_tag   = r_tag;
        n_kind  = r_kind;
        n_ok    = r_ok;
        n_found = r_found;
        n_pend  = r_pend;
        n_pslot = r_pslot;
        n_ptag  = r_ptag;
        ld_out  = 1'b0;
        ld_kind = KIND_EXP;
        ld_ok   = 1'b1;
        ld_slot = ID_W'(r_pslot);
        ld_tag  = r_ptag;
        ld_last = 1'b0;
        ord_re  = 1'b0;
        ord_ra  = '0;
        ord_we  = 1'b0;
        ord_wa  = r_idx[SW-1:0];
        ord_wd  = r_ord_q;
        ent_re  = 1'b0;
        ent_ra  = r_ord_q;
        ent_we  = 1'b0;
        act_cmd = '0;
        act_idx = r_slot;

        unique case (r_state)
            S_IDLE: begin
                act_idx = SW'(i_req.slot_id);
                if (req_acc) begin
                    case (i_req.req_type)
                        REQ_ADD: begin
                            n_kind = KIND_ADD;
                            n_rid  = '0;
                            if (!any_free) begin
                                n_ok    = 1'b0;
                                n_state = S_RESP;
                            end else begin
                                n_ok    = 1'b1;
                                n_slot  = free_idx;
                                n_rid   = ID_W'(free_idx);
                                n_dl    = add_sum[TW] ? '1 : add_sum[TW-1:0];
                                n_tag   = i_req.user_tag;
                                n_idx   = r_cnt;
                                n_state = S_ADD_RD;
                            end
                        end
                        REQ_RM: begin
                            n_kind  = KIND_RM;
                            n_rid   = i_req.slot_id;
                            n_slot  = SW'(i_req.slot_id);
                            n_idx   = '0;
                            n_found = 1'b0;
                            if (!id_ok || !act_hit) begin
                                n_ok    = 1'b0;
                                n_state = S_RESP;
                            end else begin
                                n_ok    = 1'b1;
                                n_state = S_RM_RD;
                            end
                        end
                        REQ_TICK: begin
                            n_now   = tick_sum[TW] ? '1 : tick_sum[TW-1:0];
                            n_k     = '0;
                            n_pend  = 1'b0;
                            n_state = S_TK_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                if (r_idx == '0) begin
                    ord_we  = 1'b1;
                    ord_wd  = r_slot;
                    n_state = S_ADD_FIN;
                end else begin
                    ord_re  = 1'b1;
                    ord_ra  = SW'(r_idx - CW'(1));
                    n_state = S_ADD_DL;
                end
            end
            S_ADD_DL: begin
                ent_re  = 1'b1;
                n_state = S_ADD_CMP;
            end
            S_ADD_CMP: begin
                ord_we = 1'b1;
                if (ent_dl > r_dl) begin
                    n_idx   = r_idx - CW'(1);
                    n_state = S_ADD_RD;
                end else begin
                    ord_wd  = r_slot;
                    n_state = S_ADD_FIN;
                end
            end
            S_ADD_FIN: begin
                ent_we      = 1'b1;
                act_cmd.set = 1'b1;
                n_cnt       = r_cnt + CW'(1);
                n_state     = S_RESP;
            end
            S_RM_RD: begin
                ord_re  = 1'b1;
                ord_ra  = r_idx[SW-1:0];
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                ord_wa  = SW'(r_idx - CW'(1));
                ord_we  = r_found;
                n_found = r_found || (r_ord_q == r_slot);
                n_idx   = r_idx + CW'(1);
                if (rm_next == {1'b0, r_cnt}) begin
                    act_cmd.clr = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                    n_state     = S_RESP;
                end else begin
                    n_state = S_RM_RD;
                end
            end
            S_TK_RD: begin
                if (r_k == r_cnt ||
                    {{(32 - CW){1'b0}}, r_k} >= 32'(MAX_RESULTS)) begin
                    n_state = S_TK_END;
                end else begin
                    ord_re  = 1'b1;
                    ord_ra  = r_k[SW-1:0];
                    n_state = S_TK_DL;
                end
            end
            S_TK_DL: begin
                ent_re  = 1'b1;
                n_state = S_TK_CMP;
            end
            S_TK_CMP: begin
                act_idx = r_ord_q;
                if (!due) begin
                    n_state = S_TK_END;
                end else if (!r_pend || out_free) begin
                    ld_out      = r_pend;
                    act_cmd.clr = 1'b1;
                    n_pend      = 1'b1;
                    n_pslot     = r_ord_q;
                    n_ptag      = r_ent_q[TAG_W-1:0];
                    n_k         = r_k + CW'(1);
                    n_state     = S_TK_RD;
                end
            end
            S_TK_END: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    ld_out  = 1'b1;
                    ld_last = 1'b1;
                    n_pend  = 1'b0;
                    n_idx   = '0;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (sh_src >= {1'b0, r_cnt}) begin
                    n_cnt   = r_cnt - r_k;
                    n_state = S_IDLE;
                end else begin
                    ord_re  = 1'b1;
                    ord_ra  = sh_src[SW-1:0];
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ord_we  = 1'b1;
                n_idx   = r_idx + CW'(1);
                n_state = S_SH_RD;
            end
            S_RESP: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_kind = r_kind;
                    ld_ok   = r_ok;
                    ld_slot = r_ok || (r_kind == KIND_RM) ? r_rid : '0;
                    ld_tag  = '0;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_resp.valid     = r_out_valid;
    assign o_resp.resp_kind = r_out_kind;
    assign o_resp.ok        = r_out_ok;
    assign o_resp.slot_out  = r_out_slot;
    assign o_resp.tag_out   = r_out_tag;
    assign o_resp.last      = r_out_last;

    `TSQ_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, {1'b0, r_cnt} <= (CW + 1)'(NUM_TIMERS))
    `TSQ_ASSERT_IMP(a_exp_ok, i_clk, i_rst_n, r_out_valid && r_out_kind == KIND_EXP, r_out_ok)
    `TSQ_ASSERT_NXT(a_tick_walk, i_clk, i_rst_n, req_acc && i_req.req_type == REQ_TICK, r_state == S_TK_RD)
endmodule

### rtl/tsq_active_set.sv
// per-slot active flags with lowest-free-slot search
// depends on tsq_pkg
module tsq_active_set #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsq_pkg::t_act_cmd             i_cmd,
    input  logic [$clog2(NUM_TIMERS)-1:0] i_idx,
    output logic                          o_hit,
    output logic                          o_any_free,
    output logic [$clog2(NUM_TIMERS)-1:0] o_free_idx
);
    import tsq_pkg::*;
    localparam int SW = $clog2(NUM_TIMERS);

    logic [NUM_TIMERS-1:0] r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else if (i_cmd.set) begin
            r_act[i_idx] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_act[i_idx] <= 1'b0;
        end
    end

    always_comb begin
        o_any_free = 1'b0;
        o_free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_act[i]) begin
                o_any_free = 1'b1;
                o_free_idx = SW'(i);
            end
        end
    end

    assign o_hit = r_act[i_idx];
endmodule
